FILE: hdl/aosba_pkg.sv
// Shared constants, types and register codes for the offset/scale boxcar averager.
`default_nettype none

package aosba_pkg;

    localparam int WINDOW  = 20;
    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int AXES    = 3;

    localparam int RAW_W   = 16;
    localparam int OFS_W   = 11;
    localparam int GAIN_W  = 8;
    localparam int CORR_W  = RAW_W + 1;
    localparam int MUL_W   = CORR_W + GAIN_W + 1;
    localparam int SCL_W   = 25;
    localparam int SUM_W   = 31;
    localparam int AVG_W   = 16;
    localparam int QUO_W   = AVG_W + 1;

    localparam int TDATA_W = AXES * RAW_W;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Clamp bounds on the running sum: beyond them the truncated mean saturates.
    localparam int LIM_POS = 32767 * WINDOW + WINDOW - 1;
    localparam int LIM_NEG = 32768 * WINDOW + WINDOW - 1;
    localparam int MAG_W   = $clog2(LIM_NEG + 1);

    // Reciprocal of the window length, exact for magnitudes below 2**DIV_K / WINDOW.
    localparam int DIV_K   = 28;
    localparam int RECIP   = (2 ** DIV_K + WINDOW - 1) / WINDOW;
    localparam int RECIP_W = $clog2(RECIP + 1);
    localparam int PROD_W  = ((MAG_W + RECIP_W) > (DIV_K + QUO_W)) ?
                             (MAG_W + RECIP_W) : (DIV_K + QUO_W);

    localparam int OQ_DEPTH = 8;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam logic [SLOT_W-1:0]        SLOT_LAST   = SLOT_W'(WINDOW - 1);
    localparam logic signed [SUM_W-1:0]  SUM_LIM_POS = SUM_W'(LIM_POS);
    localparam logic signed [SUM_W-1:0]  SUM_LIM_NEG = SUM_W'(-LIM_NEG);
    localparam logic [MAG_W-1:0]         MAG_LIM_POS = MAG_W'(LIM_POS);
    localparam logic [MAG_W-1:0]         MAG_LIM_NEG = MAG_W'(LIM_NEG);
    localparam logic [PROD_W-1:0]        RECIP_C     = PROD_W'(RECIP);

    localparam logic signed [OFS_W-1:0]  OFFSET_X_RST   = 11'sd2;
    localparam logic signed [OFS_W-1:0]  OFFSET_Y_RST   = -11'sd14;
    localparam logic signed [OFS_W-1:0]  OFFSET_Z_RST   = -11'sd290;
    localparam logic [GAIN_W-1:0]        SCALE_GAIN_RST = 8'd15;

    typedef enum logic [1:0] {
        REG_OFFSET_X   = 2'd0,
        REG_OFFSET_Y   = 2'd1,
        REG_OFFSET_Z   = 2'd2,
        REG_SCALE_GAIN = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [OFS_W-1:0] offset_x;
        logic signed [OFS_W-1:0] offset_y;
        logic signed [OFS_W-1:0] offset_z;
        logic [GAIN_W-1:0]       scale_gain;
    } t_cfg;

    typedef logic [AXES-1:0][RAW_W-1:0] t_raw_vec;
    typedef logic [AXES-1:0][SCL_W-1:0] t_scl_vec;
    typedef logic [AXES-1:0][SUM_W-1:0] t_sum_vec;
    typedef logic [AXES-1:0][AVG_W-1:0] t_avg_vec;

endpackage

`default_nettype wire

FILE: hdl/accel_offset_scale_boxcar_average.sv
// Top level of the three-axis offset/scale boxcar averager.
//
// Slave stream: one beat carries raw_x, raw_y, raw_z (16-bit signed each).
// Master stream: one beat per input beat with avg_x, avg_y, avg_z, the
// truncated mean over the last WINDOW scaled samples, saturated to 16 bits.
// APB port: offset_x/y/z at 0x0/0x4/0x8, scale_gain at 0xC; write only idle.
// Throughput: one beat per cycle while s_axis_tready is high; ring writes
// still in flight are forwarded to the entry read-modify-write. Results
// are registered in the ring, divider and output queue on their way out.
// Reset clears the running sums and slot pointer; ring entries read as zero
// until the write pointer has wrapped once, so no clearing pass is needed.
// A stalled receiver fills an 8-beat output queue; s_axis_tready drops once
// 8 beats are outstanding between acceptance and delivery, and nothing is
// lost or reordered.
`default_nettype none

module accel_offset_scale_boxcar_average (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // raw_x [15:0], raw_y [31:16], raw_z [47:32]
    input  wire logic [aosba_pkg::TDATA_W-1:0] s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // avg_x [15:0], avg_y [31:16], avg_z [47:32]
    output logic      [aosba_pkg::TDATA_W-1:0] m_axis_tdata,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [aosba_pkg::PADDR_W-1:0] paddr,
    input  wire logic [aosba_pkg::PDATA_W-1:0] pwdata,
    output logic      [aosba_pkg::PDATA_W-1:0] prdata,
    output logic                               pready
);
    import aosba_pkg::*;

    t_cfg        cfg;
    logic        take;
    logic        ring_valid;
    t_sum_vec    ring_sum;
    logic [AXES-1:0] div_valid;
    t_avg_vec    avg;

    assign take = s_axis_tvalid && s_axis_tready;

    aosba_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    aosba_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (take),
        .i_raw   (s_axis_tdata),
        .i_cfg   (cfg),
        .o_valid (ring_valid),
        .o_sum   (ring_sum)
    );

    for (genvar a = 0; a < AXES; a++) begin : g_div
        aosba_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (ring_valid),
            .i_sum   ($signed(ring_sum[a])),
            .o_valid (div_valid[a]),
            .o_avg   (avg[a])
        );
    end

    aosba_oq u_oq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .o_room      (s_axis_tready),
        .i_push      (&div_valid),
        .i_push_data (avg),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: hdl/aosba_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module aosba_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/aosba_cfg.sv
// Configuration register bank behind the APB-style port.
`default_nettype none

module aosba_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [aosba_pkg::PADDR_W-1:0] paddr,
    input  wire logic [aosba_pkg::PDATA_W-1:0] pwdata,
    output logic      [aosba_pkg::PDATA_W-1:0] prdata,
    output logic                               pready,
    output aosba_pkg::t_cfg                    o_cfg
);
    import aosba_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_x   <= OFFSET_X_RST;
            r_cfg.offset_y   <= OFFSET_Y_RST;
            r_cfg.offset_z   <= OFFSET_Z_RST;
            r_cfg.scale_gain <= SCALE_GAIN_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_OFFSET_X:   r_cfg.offset_x   <= pwdata[OFS_W-1:0];
                REG_OFFSET_Y:   r_cfg.offset_y   <= pwdata[OFS_W-1:0];
                REG_OFFSET_Z:   r_cfg.offset_z   <= pwdata[OFS_W-1:0];
                REG_SCALE_GAIN: r_cfg.scale_gain <= pwdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_OFFSET_X:   prdata = PDATA_W'(r_cfg.offset_x);
            REG_OFFSET_Y:   prdata = PDATA_W'(r_cfg.offset_y);
            REG_OFFSET_Z:   prdata = PDATA_W'(r_cfg.offset_z);
            REG_SCALE_GAIN: prdata = PDATA_W'(r_cfg.scale_gain);
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/aosba_ring.sv
// Offset, scale and ring-buffer running-sum update for all three axes.
`default_nettype none

module aosba_ring (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire aosba_pkg::t_raw_vec i_raw,
    input  wire aosba_pkg::t_cfg     i_cfg,
    output logic                     o_valid,
    output aosba_pkg::t_sum_vec      o_sum
);
    import aosba_pkg::*;

    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;
    logic              r_wrapped;

    logic                    r1_valid;
    logic                    r1_zero;
    logic [SLOT_W-1:0]       r1_slot;
    logic signed [CORR_W-1:0] r1_corr [AXES];

    logic                    r2_valid;
    logic                    r2_zero;
    logic [SLOT_W-1:0]       r2_slot;
    t_scl_vec                r2_scl;
    t_scl_vec                r2_old;

    logic                    r_d1_valid;
    logic [SLOT_W-1:0]       r_d1_slot;
    t_scl_vec                r_d1_data;
    logic                    r_d2_valid;
    logic [SLOT_W-1:0]       r_d2_slot;
    t_scl_vec                r_d2_data;

    logic signed [SUM_W-1:0] r_sum [AXES];
    logic signed [SUM_W-1:0] n_sum [AXES];
    logic                    r3_valid;

    logic signed [OFS_W-1:0]  ofs    [AXES];
    logic signed [CORR_W-1:0] n_corr [AXES];
    logic signed [MUL_W-1:0]  mul    [AXES];
    t_scl_vec                 n_scl;
    t_scl_vec                 ram_rdata;
    t_scl_vec                 old_vec;

    assign ofs[0] = i_cfg.offset_x;
    assign ofs[1] = i_cfg.offset_y;
    assign ofs[2] = i_cfg.offset_z;

    assign n_slot = (r_slot == SLOT_LAST) ? '0 : r_slot + SLOT_W'(1);

    aosba_ram #(
        .WIDTH (AXES * SCL_W),
        .DEPTH (WINDOW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (r2_valid),
        .i_waddr (r2_slot),
        .i_wdata (r2_scl),
        .i_re    (i_valid),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            n_corr[a] = CORR_W'($signed(i_raw[a])) + CORR_W'(ofs[a]);
            mul[a]    = r1_corr[a] * $signed({1'b0, i_cfg.scale_gain});
            n_scl[a]  = mul[a][SCL_W-1:0];
        end
    end

    // Forward writes that landed after this entry was read
    always_comb begin
        if (r_d1_valid && (r_d1_slot == r2_slot)) begin
            old_vec = r_d1_data;
        end else if (r_d2_valid && (r_d2_slot == r2_slot)) begin
            old_vec = r_d2_data;
        end else if (r2_zero) begin
            old_vec = '0;
        end else begin
            old_vec = r2_old;
        end
        for (int a = 0; a < AXES; a++) begin
            n_sum[a] = r_sum[a] - SUM_W'($signed(old_vec[a]))
                     + SUM_W'($signed(r2_scl[a]));
            o_sum[a] = r_sum[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot     <= '0;
            r_wrapped  <= 1'b0;
            r1_valid   <= 1'b0;
            r2_valid   <= 1'b0;
            r3_valid   <= 1'b0;
            r_d1_valid <= 1'b0;
            r_d2_valid <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                r_sum[a] <= '0;
            end
        end else begin
            r1_valid   <= i_valid;
            r2_valid   <= r1_valid;
            r3_valid   <= r2_valid;
            r_d1_valid <= r2_valid;
            r_d2_valid <= r_d1_valid;
            if (i_valid) begin
                r_slot <= n_slot;
                if (r_slot == SLOT_LAST) begin
                    r_wrapped <= 1'b1;
                end
            end
            if (r2_valid) begin
                for (int a = 0; a < AXES; a++) begin
                    r_sum[a] <= n_sum[a];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r1_zero   <= !r_wrapped;
        r1_slot   <= r_slot;
        r1_corr   <= n_corr;
        r2_zero   <= r1_zero;
        r2_slot   <= r1_slot;
        r2_scl    <= n_scl;
        r2_old    <= ram_rdata;
        r_d1_slot <= r2_slot;
        r_d1_data <= r2_scl;
        r_d2_slot <= r_d1_slot;
        r_d2_data <= r_d1_data;
    end

    assign o_valid = r3_valid;

endmodule

`default_nettype wire

FILE: hdl/aosba_div.sv
// Saturating truncated division of one running sum by the window length.
`default_nettype none

module aosba_div (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    input  wire logic signed [aosba_pkg::SUM_W-1:0] i_sum,
    output logic                                    o_valid,
    output logic signed [aosba_pkg::AVG_W-1:0]      o_avg
);
    import aosba_pkg::*;

    logic [MAG_W-1:0]  n_mag;
    logic              n_neg;
    logic [SUM_W-1:0]  neg_sum;
    logic [MAG_W-1:0]  r_mag;
    logic              r_neg_a;
    logic              r_va;
    logic [PROD_W-1:0] r_prod;
    logic              r_neg_b;
    logic              r_vb;
    logic [QUO_W-1:0]  quo;
    logic [QUO_W-1:0]  n_quo;

    assign neg_sum = -i_sum;

    // Clamp to the saturation bounds, take the magnitude
    always_comb begin
        if (i_sum > SUM_LIM_POS) begin
            n_mag = MAG_LIM_POS;
            n_neg = 1'b0;
        end else if (i_sum < SUM_LIM_NEG) begin
            n_mag = MAG_LIM_NEG;
            n_neg = 1'b1;
        end else if (i_sum < 0) begin
            n_mag = neg_sum[MAG_W-1:0];
            n_neg = 1'b1;
        end else begin
            n_mag = i_sum[MAG_W-1:0];
            n_neg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag   <= n_mag;
        r_neg_a <= n_neg;
        r_prod  <= PROD_W'(r_mag) * RECIP_C;
        r_neg_b <= r_neg_a;
    end

    assign quo     = r_prod[DIV_K +: QUO_W];
    assign n_quo   = r_neg_b ? -quo : quo;
    assign o_avg   = n_quo[AVG_W-1:0];
    assign o_valid = r_vb;

endmodule

`default_nettype wire

FILE: hdl/aosba_oq.sv
// Output queue with credit count covering beats still in the pipeline.
`default_nettype none

module aosba_oq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_take,
    output logic                               o_room,
    input  wire logic                          i_push,
    input  wire logic [aosba_pkg::TDATA_W-1:0] i_push_data,
    output logic                               o_tvalid,
    input  wire logic                          i_tready,
    output logic      [aosba_pkg::TDATA_W-1:0] o_tdata
);
    import aosba_pkg::*;

    logic [TDATA_W-1:0]  r_mem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_wr_ptr;
    logic [OQ_PTR_W-1:0] r_rd_ptr;
    logic [OQ_CNT_W-1:0] r_fill;
    logic [OQ_CNT_W-1:0] r_credit;
    logic                pop;

    assign o_tvalid = (r_fill != '0);
    assign pop      = o_tvalid && i_tready;
    assign o_tdata  = r_mem[r_rd_ptr];
    assign o_room   = (r_credit < OQ_CNT_W'(OQ_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
            r_credit <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + OQ_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + OQ_PTR_W'(1);
            end
            r_fill   <= r_fill + OQ_CNT_W'(i_push) - OQ_CNT_W'(pop);
            r_credit <= r_credit + OQ_CNT_W'(i_take) - OQ_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/aosba_chk.sv
// Port-level checker for the boxcar averager, bound to the top level.
`default_nettype none

module aosba_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [aosba_pkg::TDATA_W-1:0] m_axis_tdata
);

    a_rst_no_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat offered straight after reset");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready straight after reset");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> ##6 m_axis_tvalid)
        else $error("no result beat six cycles after an accepted beat");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result beat dropped or changed");

endmodule

bind accel_offset_scale_boxcar_average aosba_chk u_aosba_chk (.*);

`default_nettype wire

FILE: dv/tb_accel_offset_scale_boxcar_average.sv
// Self-checking testbench for the three-axis offset/scale boxcar averager.
`timescale 1ns / 1ps

module tb_accel_offset_scale_boxcar_average;

    import aosba_pkg::*;

    localparam int PHASES     = 6;
    localparam int PHASE_BEATS = 140;
    localparam int IDLE_PCT   = 29;
    localparam int TAIL_CYCLES = 16;

    typedef struct {
        t_raw_vec raw;
        bit       known;
        t_avg_vec known_avg;
    } t_beat;

    typedef struct {
        bit       is_write;
        t_reg_idx idx;
        int       wval;
        t_beat    beat;
    } t_step;

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    t_raw_vec            s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic                psel          = 1'b0;
    logic                penable       = 1'b0;
    logic                pwrite        = 1'b0;
    logic [PADDR_W-1:0]  paddr         = '0;
    logic [PDATA_W-1:0]  pwdata        = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // Calibration and window state mirrored from the block
    logic signed [OFS_W-1:0] cal_ofs [AXES];
    logic [GAIN_W-1:0]       cal_gain;
    logic signed [SCL_W-1:0] ring [AXES][WINDOW];
    logic signed [SUM_W-1:0] acc [AXES];
    int                      slot;

    t_step    plan[$];
    t_beat    samples_out[$];
    t_avg_vec means_due[$];

    bit    steady;
    int    mismatches;
    int    beats_in;
    int    beats_out;
    int    reg_writes;
    string avg_name [AXES] = '{"avg_x", "avg_y", "avg_z"};

    accel_offset_scale_boxcar_average dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Timed out with %0d results outstanding", means_due.size());
        $display("tb_accel_offset_scale_boxcar_average: FAIL");
        $finish;
    end

    task automatic log_mismatch(string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function automatic t_avg_vec boxcar_update(t_raw_vec raw);
        t_avg_vec                avg;
        logic signed [SCL_W-1:0] scl;
        longint                  quo;
        int                      a;
        for (a = 0; a < AXES; a++) begin
            scl = SCL_W'((longint'($signed(raw[a])) + longint'(cal_ofs[a]))
                         * longint'(cal_gain));
            acc[a] = acc[a] - ring[a][slot] + scl;
            ring[a][slot] = scl;
            quo = longint'(acc[a]) / longint'(WINDOW);
            if (quo > 32767) begin
                quo = 32767;
            end else if (quo < -32768) begin
                quo = -32768;
            end
            avg[a] = AVG_W'(quo);
        end
        slot = (slot == WINDOW - 1) ? 0 : slot + 1;
        return avg;
    endfunction

    function automatic void add_beat(int x, int y, int z, bit known = 1'b0,
                                     int ax = 0, int ay = 0, int az = 0);
        t_step st;
        st.is_write       = 1'b0;
        st.idx            = REG_OFFSET_X;
        st.wval           = 0;
        st.beat.raw       = {RAW_W'(z), RAW_W'(y), RAW_W'(x)};
        st.beat.known     = known;
        st.beat.known_avg = {AVG_W'(az), AVG_W'(ay), AVG_W'(ax)};
        plan.push_back(st);
    endfunction

    function automatic void add_write(t_reg_idx idx, int value);
        t_step st;
        st.is_write       = 1'b1;
        st.idx            = idx;
        st.wval           = value;
        st.beat.raw       = '0;
        st.beat.known     = 1'b0;
        st.beat.known_avg = '0;
        plan.push_back(st);
    endfunction

    function automatic logic [RAW_W-1:0] pick_raw();
        case ($urandom_range(9))
            0, 1, 2, 3: return RAW_W'($urandom);
            8: begin
                case ($urandom_range(3))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            9:       return RAW_W'(int'($urandom_range(64)) - 32);
            default: return RAW_W'(int'($urandom_range(4095)) - 2048);
        endcase
    endfunction

    task automatic wait_drained();
        while (samples_out.size() != 0 || s_axis_tvalid || means_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Fill the bits above the register width with noise; the block must drop them.
    task automatic apb_write(t_reg_idx idx, int value);
        logic [PDATA_W-1:0] mask;
        logic [PDATA_W-1:0] data;
        mask = (idx == REG_SCALE_GAIN) ? PDATA_W'(8'hFF) : PDATA_W'(11'h7FF);
        data = (PDATA_W'($urandom) & ~mask) | (PDATA_W'(value) & mask);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_OFFSET_X:   cal_ofs[0] = $signed(data[OFS_W-1:0]);
            REG_OFFSET_Y:   cal_ofs[1] = $signed(data[OFS_W-1:0]);
            REG_OFFSET_Z:   cal_ofs[2] = $signed(data[OFS_W-1:0]);
            REG_SCALE_GAIN: cal_gain   = data[GAIN_W-1:0];
            default: ;
        endcase
        reg_writes++;
    endtask

    task automatic set_calibration(int ox, int oy, int oz, int gain);
        apb_write(REG_OFFSET_X, ox);
        apb_write(REG_OFFSET_Y, oy);
        apb_write(REG_OFFSET_Z, oz);
        apb_write(REG_SCALE_GAIN, gain);
    endtask

    always @(posedge i_clk) begin : stream_side
        t_beat    sent;
        t_avg_vec got;
        t_avg_vec want;
        int       a;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                sent = samples_out.pop_front();
                want = boxcar_update(sent.raw);
                means_due.push_back(sent.known ? sent.known_avg : want);
                beats_in++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                beats_out++;
                if (means_due.size() == 0) begin
                    log_mismatch($sformatf("result beat %0d with nothing expected", beats_out));
                end else begin
                    want = means_due.pop_front();
                    for (a = 0; a < AXES; a++) begin
                        if (got[a] !== want[a]) begin
                            log_mismatch($sformatf("result %0d %s: got %0d want %0d",
                                beats_out, avg_name[a], $signed(got[a]), $signed(want[a])));
                        end
                    end
                end
            end
            // Hold a beat that has not been taken yet
            if (!(s_axis_tvalid && !s_axis_tready)) begin
                if (samples_out.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= samples_out[0].raw;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        int p;
        int n;
        int ox;
        int oy;
        int oz;
        int g;
        cal_ofs[0] = OFFSET_X_RST;
        cal_ofs[1] = OFFSET_Y_RST;
        cal_ofs[2] = OFFSET_Z_RST;
        cal_gain   = SCALE_GAIN_RST;
        for (p = 0; p < AXES; p++) begin
            acc[p] = '0;
            for (n = 0; n < WINDOW; n++) begin
                ring[p][n] = '0;
            end
        end
        slot = 0;

        // Directed: reset values, both saturation rails, zero gain, bit patterns
        add_beat(0, 0, 0, 1'b1, 1, -10, -217);
        add_write(REG_SCALE_GAIN, 255);
        add_write(REG_OFFSET_X, 1023);
        add_write(REG_OFFSET_Y, 1023);
        add_write(REG_OFFSET_Z, 1023);
        add_beat(32767, 32767, 32767, 1'b1, 32767, 32767, 32767);
        add_write(REG_OFFSET_X, -1024);
        add_write(REG_OFFSET_Y, -1024);
        add_write(REG_OFFSET_Z, -1024);
        add_beat(-32768, -32768, -32768, 1'b1, -24, -36, -243);
        add_beat(-32768, -32768, -32768, 1'b1, -32768, -32768, -32768);
        add_beat(-1, 0, 1);
        add_beat(21845, -21846, 255);
        add_write(REG_SCALE_GAIN, 0);
        add_beat(32767, -32768, 12345);
        add_beat(-21846, 21845, -256);
        add_write(REG_SCALE_GAIN, 1);
        add_write(REG_OFFSET_X, 0);
        add_write(REG_OFFSET_Y, 0);
        add_write(REG_OFFSET_Z, 0);
        add_beat(1, -1, 0);
        add_beat(100, -100, 32767);
        add_beat(-32768, 32767, -1);
        add_beat(4096, -4096, 1000);
        add_beat(-7, 7, -32768);
        add_beat(32767, 32767, 32767);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_write) begin
                wait_drained();
                apb_write(plan[i].idx, plan[i].wval);
            end else begin
                samples_out.push_back(plan[i].beat);
            end
        end

        for (p = 0; p < PHASES; p++) begin
            ox = int'($urandom_range(2047)) - 1024;
            oy = int'($urandom_range(2047)) - 1024;
            oz = int'($urandom_range(2047)) - 1024;
            g  = int'($urandom_range(255));
            case (p)
                0: begin ox = 1023;  oy = -1024; oz = 0;    g = 255; end
                1: begin ox = -1024; oy = 1023;  oz = 1023; g = 1;   end
                2: g = 0;
                4: begin ox = 0;     oy = 0;     oz = 0;    g = 128; end
                default: ;
            endcase
            wait_drained();
            steady = 1'b0;
            set_calibration(ox, oy, oz, g);
            steady = (p == 1);
            for (n = 0; n < PHASE_BEATS; n++) begin
                add_beat(int'(pick_raw()), int'(pick_raw()), int'(pick_raw()));
                samples_out.push_back(plan[$].beat);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (means_due.size() != 0) begin
            log_mismatch($sformatf("%0d results never arrived", means_due.size()));
        end

        $display("Sent %0d sample beats across %0d calibration settings with %0d register writes",
                 beats_in, PHASES + 1, reg_writes);
        $display("Checked %0d averaged result beats, %0d mismatches", beats_out, mismatches);
        if (mismatches == 0) begin
            $display("tb_accel_offset_scale_boxcar_average: PASS");
        end else begin
            $display("tb_accel_offset_scale_boxcar_average: FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/aosba_pkg.sv
hdl/aosba_ram.sv
hdl/aosba_cfg.sv
hdl/aosba_ring.sv
hdl/aosba_div.sv
hdl/aosba_oq.sv
hdl/accel_offset_scale_boxcar_average.sv
hdl/aosba_chk.sv
dv/tb_accel_offset_scale_boxcar_average.sv
